### hw/rtl/adse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package adse_pkg;

    // value format shared by every result field
    localparam int VAL_W = 40;
    localparam logic signed [63:0] VAL_MAX = 64'sd549755813887;
    localparam logic signed [63:0] VAL_MIN = -64'sd549755813888;

    // register widths
    localparam int SLOPE_W  = 20;
    localparam int FACTOR_W = 23;
    localparam int OFFSET_W = 11;
    localparam int ALPHA_W  = 16;

    // configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_SLOPE  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FACTOR = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA  = 8'd3;

    localparam logic [SLOPE_W-1:0]         SLOPE_RST  = 20'd65536;
    localparam logic [FACTOR_W-1:0]        FACTOR_RST = 23'd65536;
    localparam logic signed [OFFSET_W-1:0] OFFSET_RST = 11'sd0;
    localparam logic [ALPHA_W-1:0]         ALPHA_RST  = 16'd6554;

    // zero slope means unity gain, zero alpha means about 0.001
    localparam logic [SLOPE_W-1:0] SLOPE_ONE   = 20'd65536;
    localparam logic [ALPHA_W-1:0] ALPHA_FLOOR = 16'd66;

    // default parameter values
    localparam int DEF_FRACTION_BITS = 8;
    localparam int DEF_SAMPLE_BITS   = 12;

    // smoothing datapath
    localparam int COEF_W = 17;
    localparam logic [COEF_W-1:0] ONE_Q16 = 17'd65536;
    localparam int DIFF_W = VAL_W + 1;
    localparam int PROD_W = COEF_W + 1 + DIFF_W;

    // divider: quotient bits and radix-2 steps per cycle
    localparam int DIV_W    = 64;
    localparam int DIV_STEP = 8;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED,
        ST_MUL1,
        ST_AVG1,
        ST_MUL2,
        ST_AVG2,
        ST_MUL3,
        ST_NUM,
        ST_DIV,
        ST_OUT
    } back_state_t;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [COEF_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

    // clamp to the signed 40-bit range
    function automatic logic signed [VAL_W-1:0] sat40(input logic signed [63:0] v);
        logic signed [63:0] c;
        c = v;
        if (v > VAL_MAX) begin
            c = VAL_MAX;
        end else if (v < VAL_MIN) begin
            c = VAL_MIN;
        end
        return c[VAL_W-1:0];
    endfunction

    // divide by 2^16, round to nearest, ties away from zero
    function automatic logic signed [63:0] rnd_q16(input logic signed [63:0] num);
        logic        neg;
        logic [63:0] mag;
        logic [63:0] q;
        neg = num[63];
        mag = neg ? 64'(-num) : 64'(num);
        q   = (mag + 64'd32768) >> 16;
        return neg ? -$signed(q) : $signed(q);
    endfunction

endpackage

`default_nettype wire

### hw/rtl/adse_front.sv
`timescale 1ns / 1ps
`default_nettype none

// calibration pipeline: gain, factor, rounding and offset
module adse_front #(
    parameter int FRACTION_BITS = adse_pkg::DEF_FRACTION_BITS,
    parameter int SAMPLE_BITS   = adse_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic [adse_pkg::SLOPE_W-1:0]           slope_q16,
    input  wire logic [adse_pkg::FACTOR_W-1:0]          factor_q16,
    input  wire logic signed [adse_pkg::OFFSET_W-1:0]   offset_mv,
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic [SAMPLE_BITS-1:0]                 s_sample_mv,
    output logic                                        cal_valid,
    input  wire logic                                   cal_ready,
    output logic signed [adse_pkg::VAL_W-1:0]           cal_data
);
    import adse_pkg::*;

    localparam int P1W   = SLOPE_W + SAMPLE_BITS;
    localparam int P2W   = P1W + FACTOR_W;
    localparam int SHIFT = 32 - FRACTION_BITS;
    localparam logic [P2W:0] RND_HALF = {{P2W{1'b0}}, 1'b1} << (SHIFT - 1);

    logic                    v1_reg, v2_reg, v3_reg;
    logic [P1W-1:0]          p1_reg;
    logic [P2W-1:0]          p2_reg;
    logic signed [VAL_W-1:0] cal_reg;

    logic                    ready1, ready2, ready3;
    logic [SLOPE_W-1:0]      slope_eff;
    logic [P1W-1:0]          p1_next;
    logic [P2W-1:0]          p2_next;
    logic [P2W:0]            rnd_sum;
    logic [P2W:0]            rnd_q;
    logic signed [63:0]      rnd_ext;
    logic signed [63:0]      off_ext;
    logic signed [VAL_W-1:0] cal_next;

    assign ready3 = !v3_reg || cal_ready;
    assign ready2 = !v2_reg || ready3;
    assign ready1 = !v1_reg || ready2;
    assign s_ready = ready1;

    assign slope_eff = (slope_q16 == '0) ? SLOPE_ONE : slope_q16;
    assign p1_next   = P1W'(slope_eff) * P1W'(s_sample_mv);
    assign p2_next   = P2W'(p1_reg) * P2W'(factor_q16);

    // round half up, then add the offset scaled to the fraction
    assign rnd_sum  = {1'b0, p2_reg} + RND_HALF;
    assign rnd_q    = rnd_sum >> SHIFT;
    assign rnd_ext  = $signed(64'(rnd_q));
    assign off_ext  = 64'(offset_mv) <<< FRACTION_BITS;
    assign cal_next = sat40(rnd_ext + off_ext);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (ready1) begin
                v1_reg <= s_valid;
            end
            if (ready2) begin
                v2_reg <= v1_reg;
            end
            if (ready3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ready1) begin
            p1_reg <= p1_next;
        end
        if (ready2) begin
            p2_reg <= p2_next;
        end
        if (ready3) begin
            cal_reg <= cal_next;
        end
    end

    assign cal_valid = v3_reg;
    assign cal_data  = cal_reg;

endmodule

`default_nettype wire

### hw/rtl/adse_queue.sv
`timescale 1ns / 1ps
`default_nettype none

// two-entry queue of calibrated values
module adse_queue (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic signed [adse_pkg::VAL_W-1:0] in_data,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic signed [adse_pkg::VAL_W-1:0] out_data
);
    import adse_pkg::*;

    localparam int DEPTH = 2;

    logic signed [VAL_W-1:0] mem [DEPTH];
    logic                    wr_ptr_reg, rd_ptr_reg;
    logic [1:0]              count_reg;
    logic                    push, pop;

    assign in_ready  = (count_reg != 2'(DEPTH));
    assign out_valid = (count_reg != 2'd0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_data;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/adse_div.sv
`timescale 1ns / 1ps
`default_nettype none

// unsigned restoring divider, several quotient bits per cycle
module adse_div (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire adse_pkg::div_req_t req,
    output adse_pkg::div_rsp_t      rsp
);
    import adse_pkg::*;

    localparam int ITER  = DIV_W / DIV_STEP;
    localparam int CNT_W = (ITER > 1) ? $clog2(ITER) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ITER - 1);

    logic              busy_reg, done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [COEF_W-1:0] den_reg;
    logic [COEF_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0]  quo_reg, quo_next;
    logic [COEF_W:0]   part;

    always_comb begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        part     = '0;
        for (int i = 0; i < DIV_STEP; i++) begin
            part     = {rem_next, quo_next[DIV_W-1]};
            quo_next = {quo_next[DIV_W-2:0], 1'b0};
            if (part >= {1'b0, den_reg}) begin
                rem_next    = COEF_W'(part - {1'b0, den_reg});
                quo_next[0] = 1'b1;
            end else begin
                rem_next = part[COEF_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == CNT_LAST);
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            den_reg <= req.divisor;
            rem_reg <= '0;
            quo_reg <= req.dividend;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

### hw/rtl/adse_back.sv
`timescale 1ns / 1ps
`default_nettype none

// smoothing sequencer: two averages and the trend estimate on one multiplier
module adse_back (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic [adse_pkg::ALPHA_W-1:0]      alpha_q16,
    input  wire logic                              q_valid,
    output logic                                   q_ready,
    input  wire logic signed [adse_pkg::VAL_W-1:0] q_data,
    output adse_pkg::div_req_t                     div_req,
    input  wire adse_pkg::div_rsp_t                div_rsp,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic signed [adse_pkg::VAL_W-1:0]      m_calibrated,
    output logic signed [adse_pkg::VAL_W-1:0]      m_smooth_first,
    output logic signed [adse_pkg::VAL_W-1:0]      m_smooth_second
);
    import adse_pkg::*;

    back_state_t state_reg, state_next;

    logic signed [VAL_W-1:0]  cal_reg, fa_reg, sa_reg, e1_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     neg_reg;
    logic                     m_valid_reg;
    logic signed [VAL_W-1:0]  m_cal_reg, m_first_reg, m_second_reg;

    logic                     pop, mul_trend, out_load;
    logic [ALPHA_W-1:0]       a_eff;
    logic [COEF_W-1:0]        one_minus;
    logic [COEF_W-1:0]        mul_coeff;
    logic signed [DIFF_W-1:0] mul_opnd;
    logic signed [PROD_W-1:0] mul_prod;
    logic signed [VAL_W-1:0]  fa_eff, sa_eff;
    logic signed [63:0]       avg_base, avg_num;
    logic signed [VAL_W-1:0]  avg_val;
    logic signed [63:0]       trend_num;
    logic [63:0]              trend_mag;
    logic signed [63:0]       quo_signed;
    logic signed [VAL_W-1:0]  second_val;

    assign a_eff     = (alpha_q16 == '0) ? ALPHA_FLOOR : alpha_q16;
    assign one_minus = ONE_Q16 - COEF_W'(a_eff);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    state_next = ST_SEED;
                end
            end
            ST_SEED: state_next = ST_MUL1;
            ST_MUL1: state_next = ST_AVG1;
            ST_AVG1: state_next = ST_MUL2;
            ST_MUL2: state_next = ST_AVG2;
            ST_AVG2: state_next = ST_MUL3;
            ST_MUL3: state_next = ST_NUM;
            ST_NUM:  state_next = ST_DIV;
            ST_DIV: begin
                if (div_rsp.done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        q_ready   = 1'b0;
        mul_trend = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            ST_IDLE: q_ready   = 1'b1;
            ST_MUL3: mul_trend = 1'b1;
            ST_OUT:  out_load  = !m_valid_reg || m_ready;
            default: begin
            end
        endcase
    end

    assign pop = q_valid && q_ready;

    // shared multiplier: alpha times a difference, or (1-alpha) times e1
    assign mul_coeff = mul_trend ? one_minus : COEF_W'(a_eff);
    assign mul_opnd  = mul_trend ? DIFF_W'(e1_reg) : diff_reg;
    assign mul_prod  = $signed({1'b0, mul_coeff}) * mul_opnd;

    // a zero average means not yet seeded
    assign fa_eff = (fa_reg == '0) ? cal_reg : fa_reg;
    assign sa_eff = (sa_reg == '0) ? cal_reg : sa_reg;

    // average = old + a*(new-old), expressed over 2^16
    assign avg_base = (state_reg == ST_AVG2) ? 64'(sa_reg) : 64'(fa_reg);
    assign avg_num  = (avg_base <<< 16) + 64'(prod_reg);
    assign avg_val  = sat40(rnd_q16(avg_num));

    // (2-a)*e1 - e12 = (e1-e12) + (1-a)*e1, before division by (1-a)
    assign trend_num = (64'(diff_reg) <<< 16) + 64'(prod_reg);
    assign trend_mag = trend_num[63] ? 64'(-trend_num) : 64'(trend_num);

    assign div_req.start    = (state_reg == ST_NUM);
    assign div_req.dividend = trend_mag + 64'(one_minus >> 1);
    assign div_req.divisor  = one_minus;

    assign quo_signed = neg_reg ? -$signed(div_rsp.quotient) : $signed(div_rsp.quotient);
    assign second_val = sat40(quo_signed);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fa_reg      <= '0;
            sa_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                ST_SEED: begin
                    fa_reg <= fa_eff;
                    sa_reg <= sa_eff;
                end
                ST_AVG1: fa_reg <= avg_val;
                ST_AVG2: sa_reg <= avg_val;
                default: begin
                end
            endcase
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            cal_reg <= q_data;
        end
        case (state_reg)
            ST_SEED: diff_reg <= DIFF_W'(cal_reg) - DIFF_W'(fa_eff);
            ST_MUL1: prod_reg <= mul_prod;
            ST_AVG1: begin
                e1_reg   <= avg_val;
                diff_reg <= DIFF_W'(avg_val) - DIFF_W'(sa_reg);
            end
            ST_MUL2: prod_reg <= mul_prod;
            ST_AVG2: diff_reg <= DIFF_W'(e1_reg) - DIFF_W'(avg_val);
            ST_MUL3: prod_reg <= mul_prod;
            ST_NUM:  neg_reg  <= trend_num[63];
            default: begin
            end
        endcase
        if (out_load) begin
            m_cal_reg    <= cal_reg;
            m_first_reg  <= e1_reg;
            m_second_reg <= second_val;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_calibrated    = m_cal_reg;
    assign m_smooth_first  = m_first_reg;
    assign m_smooth_second = m_second_reg;

endmodule

`default_nettype wire

### hw/rtl/adc_double_exponential_smoother_top.sv
`timescale 1ns / 1ps
`default_nettype none

// channel    direction  transfer when         payload
// s_         in         s_valid & s_ready     s_sample_mv (mV, low SAMPLE_BITS used)
// m_         out        m_valid & m_ready     m_calibrated, m_smooth_first, m_smooth_second
// cfg_       in         cfg_valid & cfg_ready cfg_index, cfg_data (always ready)
//
// the front calibrates in a 3-stage pipeline and feeds a 2-entry queue
// the back takes one sample at a time: seed, three multiply and two average steps on one
// shared 18x41 multiplier, numerator, divide (8 bits a step, then done), result load
// a result waiting on m_ready holds the back, the queue and then the front fill
// aresetn is synchronous, active low; it restores register defaults and
// clears both averages to the unseeded state
module adc_double_exponential_smoother_top #(
    parameter int FRACTION_BITS = adse_pkg::DEF_FRACTION_BITS,
    parameter int SAMPLE_BITS   = adse_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // sample input
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic [SAMPLE_BITS-1:0]                s_sample_mv,
    // result output
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic signed [adse_pkg::VAL_W-1:0]          m_calibrated,
    output logic signed [adse_pkg::VAL_W-1:0]          m_smooth_first,
    output logic signed [adse_pkg::VAL_W-1:0]          m_smooth_second,
    // register writes
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [adse_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [adse_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import adse_pkg::*;

    // configuration registers
    logic [SLOPE_W-1:0]         slope_reg;
    logic [FACTOR_W-1:0]        factor_reg;
    logic signed [OFFSET_W-1:0] offset_reg;
    logic [ALPHA_W-1:0]         alpha_reg;

    // front to queue
    logic                    fq_valid, fq_ready;
    logic signed [VAL_W-1:0] fq_data;

    // queue to back
    logic                    qb_valid, qb_ready;
    logic signed [VAL_W-1:0] qb_data;

    // back to divider
    div_req_t div_req;
    div_rsp_t div_rsp;

    assign cfg_ready = 1'b1;

    // unknown indexes are dropped, upper data bits ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slope_reg  <= SLOPE_RST;
            factor_reg <= FACTOR_RST;
            offset_reg <= OFFSET_RST;
            alpha_reg  <= ALPHA_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_SLOPE:  slope_reg  <= cfg_data[SLOPE_W-1:0];
                REG_FACTOR: factor_reg <= cfg_data[FACTOR_W-1:0];
                REG_OFFSET: offset_reg <= $signed(cfg_data[OFFSET_W-1:0]);
                REG_ALPHA:  alpha_reg  <= cfg_data[ALPHA_W-1:0];
                default: begin
                end
            endcase
        end
    end

    adse_front #(
        .FRACTION_BITS (FRACTION_BITS),
        .SAMPLE_BITS   (SAMPLE_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .slope_q16   (slope_reg),
        .factor_q16  (factor_reg),
        .offset_mv   (offset_reg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_sample_mv (s_sample_mv),
        .cal_valid   (fq_valid),
        .cal_ready   (fq_ready),
        .cal_data    (fq_data)
    );

    adse_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_data)
    );

    adse_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    adse_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .alpha_q16       (alpha_reg),
        .q_valid         (qb_valid),
        .q_ready         (qb_ready),
        .q_data          (qb_data),
        .div_req         (div_req),
        .div_rsp         (div_rsp),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_calibrated    (m_calibrated),
        .m_smooth_first  (m_smooth_first),
        .m_smooth_second (m_smooth_second)
    );

endmodule

`default_nettype wire
